// ===== rtl/core/mnrt_pkg.sv =====
// Package for the MIDI note remap table: entry layout, sequencer states,
// register indexes, MIDI type codes and default parameters.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mnrt_pkg;

  // Default sizing
  localparam int GROUPS_DEF  = 4;
  localparam int ENTRIES_DEF = 8;

  // Port widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 1;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;

  // Number of groups that have a count register
  localparam int COUNT_REGS = 4;

  // MIDI codes
  localparam logic [7:0] TYPE_NOTE_OFF = 8'h80;
  localparam logic [7:0] TYPE_NOTE_ON  = 8'h90;
  localparam logic [7:0] HIGH_NIBBLE   = 8'hF0;
  localparam logic [7:0] LOW_NIBBLE    = 8'h0F;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_ACTIVE = 3'd0;
  localparam logic [2:0] REG_COUNT0 = 3'd1;
  localparam logic [2:0] REG_COUNT1 = 3'd2;
  localparam logic [2:0] REG_COUNT2 = 3'd3;
  localparam logic [2:0] REG_COUNT3 = 3'd4;

  // One table slot, 30 bits
  typedef struct packed {
    logic [6:0] target_data;
    logic [7:0] target_status;
    logic [6:0] match_data;
    logic [7:0] match_status;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/midi_note_remap_table.sv =====
// MIDI note remap table: table memory, scan sequencer, shared match unit.
// Depends on mnrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Remaps MIDI channel messages through a table of GROUPS x ENTRIES_PER_GROUP
// match/target slots. An input transfer with in_tuser = 0 writes one slot. An
// input transfer with in_tuser = 1 presents a packet: a sequencer walks every
// slot address once, one memory read per cycle while the scan does not stall,
// and a single shared match/rewrite unit checks each slot in use (active
// group, slot below that group's count) against the packet as the earlier
// matches left it. Extra note-on/note-off messages come out in scan order,
// followed by one final item (out_tlast = 1) that carries the remapped packet
// and its pass flag. The scan reads the table through its single read port
// and stalls while an extra is pending and the result side is not free; the
// final item waits for the output register. in_tready is high only between
// packets; the output register lets the next transfer in while the final item
// still waits. The table has no reset: a slot must be written before any
// count register brings it into the scan. Configuration registers sit at
// byte address 4*i; they are to be written only while the block is idle,
// which the block itself does not enforce.
module midi_note_remap_table #(
  parameter int GROUPS            = mnrt_pkg::GROUPS_DEF,
  parameter int ENTRIES_PER_GROUP = mnrt_pkg::ENTRIES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input channel
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // tdata, low bit up: group_index[1:0], entry_index[4:2],
  // match_status[12:5], match_data[19:13], target_status[27:20],
  // target_data[34:28], msg_type[42:35], channel[47:43], data1[54:48],
  // data2[61:55], zero[63:62]
  input  wire logic [mnrt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: mode[0]
  input  wire logic                             in_tuser,
  // Result channel
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // tdata, low bit up: out_type[7:0], out_channel[12:8], out_first[19:13],
  // out_second[26:20], zero[31:27]
  output logic [mnrt_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // tlast: is_final
  output logic                                  out_tlast,
  // tuser: passes[0]
  output logic [mnrt_pkg::OUT_TUSER_W-1:0]      out_tuser,
  // Configuration port
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [mnrt_pkg::CFG_AW-1:0]      cfg_paddr,
  input  wire logic [mnrt_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [mnrt_pkg::CFG_DW-1:0]           cfg_prdata,
  output logic                                  cfg_pready
);
  import mnrt_pkg::*;

  // Address layout: {group, slot}, slot field padded to a power of two
  localparam int GW          = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int EW          = (ENTRIES_PER_GROUP > 1) ? $clog2(ENTRIES_PER_GROUP) : 1;
  localparam int AW          = GW + EW;
  localparam int DEPTH       = GROUPS * (2 ** EW);
  localparam int SCAN_GROUPS = (GROUPS < COUNT_REGS) ? GROUPS : COUNT_REGS;

  // ---------------------------------------------------------------
  // Input fields
  // ---------------------------------------------------------------
  logic [1:0] f_group;
  logic [2:0] f_entry;
  entry_t     f_slot;
  logic [7:0] f_type;
  logic [4:0] f_ch;
  logic [6:0] f_d1;
  logic [6:0] f_d2;

  assign f_group              = in_tdata[1:0];
  assign f_entry              = in_tdata[4:2];
  assign f_slot.match_status  = in_tdata[12:5];
  assign f_slot.match_data    = in_tdata[19:13];
  assign f_slot.target_status = in_tdata[27:20];
  assign f_slot.target_data   = in_tdata[34:28];
  assign f_type               = in_tdata[42:35];
  assign f_ch                 = in_tdata[47:43];
  assign f_d1                 = in_tdata[54:48];
  assign f_d2                 = in_tdata[61:55];

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [3:0] active_r;
  logic [3:0] cnt_r [COUNT_REGS];
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      for (int k = 0; k < COUNT_REGS; k++) cnt_r[k] <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ACTIVE: active_r <= cfg_pwdata[3:0];
        REG_COUNT0: cnt_r[0] <= cfg_pwdata[3:0];
        REG_COUNT1: if (GROUPS > 1) cnt_r[1] <= cfg_pwdata[3:0];
        REG_COUNT2: if (GROUPS > 2) cnt_r[2] <= cfg_pwdata[3:0];
        REG_COUNT3: if (GROUPS > 3) cnt_r[3] <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_ACTIVE: cfg_prdata[3:0] = active_r;
      REG_COUNT0: cfg_prdata[3:0] = cnt_r[0];
      REG_COUNT1: cfg_prdata[3:0] = cnt_r[1];
      REG_COUNT2: cfg_prdata[3:0] = cnt_r[2];
      REG_COUNT3: cfg_prdata[3:0] = cnt_r[3];
      default: cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Sequencer state and packet under remap
  // ---------------------------------------------------------------
  state_t      state_r, state_nxt;
  logic [AW:0] ptr_r;          // next slot address to read
  logic        s2_valid_r;     // rd_data_r holds a scanned slot
  logic        s2_live_r;      // ... and that slot is in use
  entry_t      rd_data_r;
  logic [7:0]  p_type_r;
  logic [4:0]  p_ch_r;
  logic [6:0]  p_d1_r;
  logic [6:0]  p_d2_r;
  logic        pass_r;

  logic        in_xfer;
  logic        start;
  logic        issuing;
  logic        out_free;
  logic        stall;
  logic        advance;
  logic        rd_en;
  logic        wr_en;
  logic        load_extra;
  logic        load_final;
  logic [AW-1:0] wr_addr;

  assign in_xfer  = in_tvalid & in_tready;
  assign start    = in_xfer & in_tuser;
  assign issuing  = ptr_r < (AW+1)'(DEPTH);
  assign out_free = !out_tvalid || out_tready;

  // Out-of-range slot writes are dropped
  assign wr_en   = in_xfer && !in_tuser &&
                   (int'(f_group) < GROUPS) && (int'(f_entry) < ENTRIES_PER_GROUP);
  assign wr_addr = AW'(int'(f_group) * (2 ** EW) + int'(f_entry));

  // ---------------------------------------------------------------
  // Table memory, one write and one registered read port
  // ---------------------------------------------------------------
  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= f_slot;
    if (rd_en) rd_data_r <= mem[ptr_r[AW-1:0]];
  end

  // Slot in use: group has a count register, is active, slot below count
  logic          live;
  logic [GW-1:0] ptr_g;
  logic [EW-1:0] ptr_j;

  assign ptr_g = ptr_r[AW-1:EW];
  assign ptr_j = ptr_r[EW-1:0];

  always_comb begin
    logic [4:0] cnt5;
    logic [4:0] lim;
    live = 1'b0;
    lim  = 5'(ENTRIES_PER_GROUP);
    for (int gg = 0; gg < SCAN_GROUPS; gg++) begin
      cnt5 = {1'b0, cnt_r[gg]};
      if (cnt5 > lim) cnt5 = lim;
      if (ptr_g == GW'(gg) && active_r[gg] && (5'(ptr_j) < cnt5)) live = 1'b1;
    end
  end

  // ---------------------------------------------------------------
  // Shared match / rewrite unit
  // ---------------------------------------------------------------
  logic       hit;
  logic       emit_req;
  logic [7:0] em_type;
  logic [4:0] tch1;
  logic [7:0] type_nxt;
  logic [4:0] ch_nxt;
  logic [6:0] d1_nxt;
  logic       pass_nxt;

  always_comb begin
    logic [7:0] m_type;
    logic [7:0] t_type;
    m_type   = rd_data_r.match_status & HIGH_NIBBLE;
    t_type   = rd_data_r.target_status & HIGH_NIBBLE;
    tch1     = {1'b0, rd_data_r.target_status[3:0]} + 5'd1;
    // a channel of zero or above sixteen never lines up with a 4-bit channel
    hit      = s2_valid_r && s2_live_r && (p_ch_r != 5'd0) &&
               ((p_ch_r - 5'd1) == {1'b0, rd_data_r.match_status[3:0]}) &&
               (rd_data_r.match_data == p_d1_r);
    emit_req = 1'b0;
    em_type  = TYPE_NOTE_ON;
    type_nxt = p_type_r;
    ch_nxt   = p_ch_r;
    d1_nxt   = p_d1_r;
    pass_nxt = pass_r;
    if (hit) begin
      if (p_type_r == TYPE_NOTE_OFF) begin
        if (m_type == TYPE_NOTE_ON &&
            (t_type == TYPE_NOTE_ON || t_type == TYPE_NOTE_OFF)) begin
          ch_nxt = tch1;
          if (t_type == TYPE_NOTE_OFF) begin
            emit_req = 1'b1;
            em_type  = TYPE_NOTE_OFF;
          end else begin
            d1_nxt = rd_data_r.target_data;
          end
        end else begin
          pass_nxt = 1'b0;       // orphan note-off, scan continues
        end
      end else if (p_type_r == m_type) begin
        if (t_type == TYPE_NOTE_OFF) begin
          emit_req = 1'b1;       // stacked note-on
          em_type  = TYPE_NOTE_ON;
        end else begin
          type_nxt = t_type;
          ch_nxt   = tch1;
          d1_nxt   = rd_data_r.target_data;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_SCAN;
      ST_SCAN:  if (!issuing && !s2_valid_r) state_nxt = ST_FINAL;
      ST_FINAL: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_tready  = 1'b0;
    stall      = 1'b0;
    load_final = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_tready  = 1'b1;
      ST_SCAN:  stall      = emit_req && !out_free;
      ST_FINAL: load_final = out_free;
      default: ;
    endcase
    advance    = (state_r == ST_SCAN) && !stall;
    rd_en      = advance && issuing;
    load_extra = advance && emit_req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      s2_valid_r <= 1'b0;
      ptr_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        ptr_r      <= '0;
        s2_valid_r <= 1'b0;
      end else if (advance) begin
        s2_valid_r <= issuing;
        if (issuing) ptr_r <= ptr_r + 1'b1;
      end
    end
  end

  // Packet registers; rewrite applied only on a cycle that moves the scan
  always_ff @(posedge clk) begin
    if (start) begin
      p_type_r <= f_type;
      p_ch_r   <= f_ch;
      p_d1_r   <= f_d1;
      p_d2_r   <= f_d2;
      pass_r   <= 1'b1;
    end else if (advance) begin
      p_type_r  <= type_nxt;
      p_ch_r    <= ch_nxt;
      p_d1_r    <= d1_nxt;
      pass_r    <= pass_nxt;
      s2_live_r <= live;
    end
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  logic       out_valid_r;
  logic [7:0] o_type_r;
  logic [4:0] o_ch_r;
  logic [6:0] o_d1_r;
  logic [6:0] o_d2_r;
  logic       o_final_r;
  logic       o_pass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_extra || load_final) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_extra) begin
      o_type_r  <= em_type;
      o_ch_r    <= tch1;
      o_d1_r    <= rd_data_r.target_data;
      o_d2_r    <= p_d2_r;
      o_final_r <= 1'b0;
      o_pass_r  <= 1'b0;
    end else if (load_final) begin
      o_type_r  <= p_type_r;
      o_ch_r    <= p_ch_r;
      o_d1_r    <= p_d1_r;
      o_d2_r    <= p_d2_r;
      o_final_r <= 1'b1;
      o_pass_r  <= pass_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, o_d2_r, o_d1_r, o_ch_r, o_type_r};
  assign out_tlast  = o_final_r;
  assign out_tuser  = o_pass_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && stall) |=> ($stable(ptr_r) && $stable(p_type_r) &&
                                       $stable(p_ch_r) && $stable(p_d1_r)))
    else $error("scan moved during output stall");

  a_final_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    load_final |-> (!s2_valid_r && !issuing))
    else $error("final item loaded before scan drained");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= (AW+1)'(DEPTH))
    else $error("scan pointer past table");

  a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (state_r == ST_SCAN && ptr_r == '0 && pass_r))
    else $error("packet did not start a scan");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (load_extra || load_final) |-> (!out_valid_r || out_tready))
    else $error("output register overwritten");

endmodule

`default_nettype wire
